@@ rtl/core/nubf_pkg.sv @@
// ----------------------------------------------------------------------------
// nubf_pkg
// shared constants and types for the annex b nal unit boundary finder
// ----------------------------------------------------------------------------
package nubf_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF  = 14;
  localparam int MAX_UNITS_RESET = 9000;

  // event queue between scanner and result sequencer
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_START = 2'd1;
  localparam logic [1:0] STATUS_LIMIT    = 2'd2;

  localparam logic [7:0] START_CODE_END  = 8'h01;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/core/nubf_front.sv @@
// ----------------------------------------------------------------------------
// nubf_front
// scans bytes, tracks the open unit and queues one event per byte that ends a
// unit or the buffer; an event holds one or two result items
// ----------------------------------------------------------------------------
module nubf_front #(
  parameter int OFFSET_BITS = nubf_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = nubf_pkg::COUNT_BITS_DEF,
  parameter int ENT_W       = 2 * (3 * OFFSET_BITS + COUNT_BITS + 12) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last,
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_data,
  output logic                  ent_push,
  output logic [ENT_W-1:0]      ent_data
);
  import nubf_pkg::*;

  localparam int O = OFFSET_BITS;
  localparam int C = COUNT_BITS;
  localparam logic [C-1:0] MAX_RESET =
    (MAX_UNITS_RESET >= (1 << C)) ? {C{1'b1}} : C'(MAX_UNITS_RESET);

  logic [C-1:0]  max_units;
  logic [15:0]   prev_two;
  logic [O-1:0]  byte_pos;
  logic [O-1:0]  unit_start;
  logic [7:0]    cur_type;
  logic          type_pend;
  logic          seen;
  logic [C-1:0]  unit_count;
  logic          limit_hit;

  logic          take_type;
  logic [7:0]    type_a;
  logic          pend_a;
  logic          start_code;
  logic          first_code;
  logic          unit_fin;
  logic [O-1:0]  code_start;
  logic [O-1:0]  len;
  logic [C-1:0]  count_inc;
  logic          inc_hits_max;
  logic [C-1:0]  unit_count_next;
  logic [O-1:0]  unit_start_next;
  logic [7:0]    cur_type_next;
  logic          type_pend_next;
  logic          seen_next;
  logic          limit_hit_next;
  logic [O+C+O+O+11:0] unit_rec;
  logic [O+C+O+O+11:0] final_rec;

  always_comb begin
    take_type    = !limit_hit && type_pend;
    type_a       = take_type ? data_byte : cur_type;
    pend_a       = take_type ? 1'b0 : type_pend;
    start_code   = (data_byte == START_CODE_END) && (prev_two == 16'h0000);
    first_code   = start_code && !seen;
    unit_fin     = start_code && seen && !limit_hit;
    code_start   = byte_pos - O'(2);
    len          = byte_pos + O'(1);
    count_inc    = unit_count + C'(1);
    inc_hits_max = count_inc >= max_units;

    unit_count_next = unit_fin ? count_inc : unit_count;
    unit_start_next = first_code ? '0 : (unit_fin ? code_start : unit_start);
    cur_type_next   = (first_code || unit_fin) ? 8'h00 : type_a;
    type_pend_next  = first_code ? 1'b1 : (unit_fin ? !inc_hits_max : pend_a);
    seen_next       = seen || start_code;
    limit_hit_next  = limit_hit || (unit_fin && inc_hits_max);

    unit_rec = {1'b1, unit_count, unit_start, code_start - unit_start, type_a,
                STATUS_OK, O'(0), 1'b0};

    if (!seen_next) begin
      final_rec = {1'b0, C'(0), O'(0), O'(0), 8'h00, STATUS_NO_START, len, 1'b1};
    end else if (limit_hit_next) begin
      final_rec = {1'b0, C'(0), O'(0), O'(0), 8'h00, STATUS_LIMIT,
                   len - unit_start_next, 1'b1};
    end else begin
      final_rec = {1'b1, unit_count_next, unit_start_next, len - unit_start_next,
                   type_pend_next ? 8'h00 : cur_type_next, STATUS_OK, O'(0), 1'b1};
    end

    ent_push = accept && (unit_fin || last);
    ent_data = {unit_fin && last, unit_fin ? unit_rec : final_rec, final_rec};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= MAX_RESET;
    end else if (cfg_we) begin
      max_units <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      prev_two   <= 16'hFFFF;
      byte_pos   <= '0;
      unit_start <= '0;
      cur_type   <= 8'h00;
      type_pend  <= 1'b0;
      seen       <= 1'b0;
      unit_count <= '0;
      limit_hit  <= 1'b0;
    end else if (accept) begin
      prev_two   <= {prev_two[7:0], data_byte};
      byte_pos   <= len;
      unit_start <= unit_start_next;
      cur_type   <= cur_type_next;
      type_pend  <= type_pend_next;
      seen       <= seen_next;
      unit_count <= unit_count_next;
      limit_hit  <= limit_hit_next;
    end
  end

endmodule

@@ rtl/core/nubf_queue.sv @@
// ----------------------------------------------------------------------------
// nubf_queue
// short event queue between scanner and result sequencer
// ----------------------------------------------------------------------------
module nubf_queue #(
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output nubf_pkg::q_status_t        qst
);
  import nubf_pkg::*;

  logic [WIDTH-1:0]   mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign qst.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign qst.empty = (count == '0);
  assign do_wr     = wr_en && !qst.full;
  assign do_rd     = rd_en && !qst.empty;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/nubf_back.sv @@
// ----------------------------------------------------------------------------
// nubf_back
// result sequencer: presents the one or two items of the head event in order
// ----------------------------------------------------------------------------
module nubf_back #(
  parameter int OFFSET_BITS = nubf_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = nubf_pkg::COUNT_BITS_DEF,
  parameter int ENT_W       = 2 * (3 * OFFSET_BITS + COUNT_BITS + 12) + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ENT_W-1:0]       head,
  input  nubf_pkg::q_status_t    qst,
  input  logic                   pop,
  output logic                   q_pop,
  output logic                   unit_valid,
  output logic [COUNT_BITS-1:0]  unit_index,
  output logic [OFFSET_BITS-1:0] unit_offset,
  output logic [OFFSET_BITS-1:0] unit_size,
  output logic [7:0]             unit_type,
  output logic [1:0]             status,
  output logic [OFFSET_BITS-1:0] bytes_left,
  output logic                   done_res
);
  import nubf_pkg::*;

  localparam int REC_W = 3 * OFFSET_BITS + COUNT_BITS + 12;

  logic             sel;
  logic             two;
  logic             take;
  logic [REC_W-1:0] rec;

  assign two  = head[ENT_W-1];
  assign rec  = sel ? head[REC_W-1:0] : head[2*REC_W-1:REC_W];
  assign take = pop && !qst.empty;
  // the head event leaves the queue with its last item
  assign q_pop = take && (!two || sel);

  assign {unit_valid, unit_index, unit_offset, unit_size, unit_type, status,
          bytes_left, done_res} = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (take) begin
      sel <= two && !sel;
    end
  end

endmodule

@@ rtl/core/nal_unit_boundary_finder.sv @@
// ----------------------------------------------------------------------------
// nal_unit_boundary_finder
// splits an annex b byte stream into nal units at 00 00 01 start codes
//
//   channel  handshake                  payload
//   input    push / full                data_byte, last
//   result   empty / pop                unit_valid .. done_res
//   config   cfg_valid / cfg_ready      cfg_data (max_units)
//
// one byte is taken per cycle while the event queue has room; a byte that
// closes a unit or the buffer queues one event of one or two items, and a
// result item appears on the ports once its event reaches the queue head.
// results leave at one item per cycle while pop is high; the queue (four
// entries) lets the byte side keep running while the result side is stalled.
// reset (rst, synchronous) clears all buffer state and loads max_units 9000.
// ----------------------------------------------------------------------------
module nal_unit_boundary_finder #(
  parameter int OFFSET_BITS = nubf_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = nubf_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             data_byte,
  input  logic                   last,
  output logic                   empty,
  input  logic                   pop,
  output logic                   unit_valid,
  output logic [COUNT_BITS-1:0]  unit_index,
  output logic [OFFSET_BITS-1:0] unit_offset,
  output logic [OFFSET_BITS-1:0] unit_size,
  output logic [7:0]             unit_type,
  output logic [1:0]             status,
  output logic [OFFSET_BITS-1:0] bytes_left,
  output logic                   done_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_BITS-1:0]  cfg_data
);
  import nubf_pkg::*;

  localparam int ENT_W = 2 * (3 * OFFSET_BITS + COUNT_BITS + 12) + 1;

  q_status_t        qst;
  logic             accept;
  logic             ent_push;
  logic [ENT_W-1:0] ent_data;
  logic [ENT_W-1:0] head;
  logic             q_pop;

  assign full      = qst.full;
  assign empty     = qst.empty;
  assign accept    = push && !qst.full;
  assign cfg_ready = 1'b1;

  nubf_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(data_byte),
    .last     (last),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ent_push (ent_push),
    .ent_data (ent_data)
  );

  nubf_queue #(
    .WIDTH(ENT_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (ent_push),
    .wr_data(ent_data),
    .rd_en  (q_pop),
    .rd_data(head),
    .qst    (qst)
  );

  nubf_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qst        (qst),
    .pop        (pop),
    .q_pop      (q_pop),
    .unit_valid (unit_valid),
    .unit_index (unit_index),
    .unit_offset(unit_offset),
    .unit_size  (unit_size),
    .unit_type  (unit_type),
    .status     (status),
    .bytes_left (bytes_left),
    .done_res   (done_res)
  );

  a_q_flags : assert property (@(posedge clk) disable iff (rst)
    !(qst.full && qst.empty))
    else $error("queue full and empty together");

  a_no_unit_item : assert property (@(posedge clk) disable iff (rst)
    (!empty && !unit_valid) |-> done_res)
    else $error("item without unit that is not final");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    (!empty && unit_valid) |-> (status == STATUS_OK && bytes_left == '0))
    else $error("unit item with error status or leftover bytes");

  a_unit_queued : assert property (@(posedge clk) disable iff (rst)
    (push && !full && last) |=> !empty)
    else $error("final byte produced no item");

endmodule

@@ bench/nal_split_monitor.sv @@
// ----------------------------------------------------------------------------
// nal_split_monitor
// watches the byte, unit and max_units channels of the nal unit boundary
// finder, works out the unit records each accepted byte must produce and
// compares every popped record with the oldest one still due
// ----------------------------------------------------------------------------
module nal_split_monitor #(
  parameter int OFS_W = nubf_pkg::OFFSET_BITS_DEF,
  parameter int CNT_W = nubf_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  logic [7:0]       data_byte,
  input  logic             last,
  input  logic             empty,
  input  logic             pop,
  input  logic             unit_valid,
  input  logic [CNT_W-1:0] unit_index,
  input  logic [OFS_W-1:0] unit_offset,
  input  logic [OFS_W-1:0] unit_size,
  input  logic [7:0]       unit_type,
  input  logic [1:0]       status,
  input  logic [OFS_W-1:0] bytes_left,
  input  logic             done_res,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               errors,
  output int               owed
);

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] index;
    logic [OFS_W-1:0] offset;
    logic [OFS_W-1:0] size;
    logic [7:0]       utype;
    logic [1:0]       status;
    logic [OFS_W-1:0] left;
    logic             done;
  } unit_rec_t;

  unit_rec_t units_due[$];
  int        units_popped = 0;

  // scanner state of the buffer in flight
  logic [15:0]      last_two;
  logic [OFS_W-1:0] pos_ctr;
  logic [OFS_W-1:0] open_start;
  logic [7:0]       open_type;
  logic             type_due;
  logic             found_code;
  logic [CNT_W-1:0] units_given;
  logic             at_limit;
  logic [CNT_W-1:0] max_units;

  initial errors = 0;
  initial owed = 0;

  task automatic log_error(input string msg);
    $display("%0t  %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      log_error($sformatf("unit item %0d: %s is %0h, %0h expected", units_popped, name,
                          got, want));
  endtask

  function automatic unit_rec_t make_rec(input logic valid, input logic [CNT_W-1:0] index,
                                         input logic [OFS_W-1:0] offset,
                                         input logic [OFS_W-1:0] size,
                                         input logic [7:0] utype, input logic [1:0] st,
                                         input logic [OFS_W-1:0] left, input logic done);
    unit_rec_t r;
    r.valid  = valid;
    r.index  = index;
    r.offset = offset;
    r.size   = size;
    r.utype  = utype;
    r.status = st;
    r.left   = left;
    r.done   = done;
    return r;
  endfunction

  task automatic clear_scan();
    last_two    = 16'hFFFF;
    pos_ctr     = '0;
    open_start  = '0;
    open_type   = 8'h00;
    type_due    = 1'b0;
    found_code  = 1'b0;
    units_given = '0;
    at_limit    = 1'b0;
  endtask

  task automatic split_byte(input logic [7:0] b, input logic fin);
    logic [OFS_W-1:0] pos;
    logic [OFS_W-1:0] code_at;
    logic [OFS_W-1:0] len;
    pos = pos_ctr;
    if (!at_limit && type_due) begin
      open_type = b;
      type_due  = 1'b0;
    end
    if (b == nubf_pkg::START_CODE_END && last_two == 16'h0000) begin
      if (!found_code) begin
        // first code: unit 0 keeps any bytes ahead of it
        found_code = 1'b1;
        open_start = '0;
        open_type  = 8'h00;
        type_due   = 1'b1;
      end else if (!at_limit) begin
        code_at = pos - OFS_W'(2);
        units_due.push_back(make_rec(1'b1, units_given, open_start, code_at - open_start,
                                     open_type, nubf_pkg::STATUS_OK, '0, 1'b0));
        units_given = units_given + CNT_W'(1);
        open_start  = code_at;
        open_type   = 8'h00;
        if (units_given >= max_units) begin
          at_limit = 1'b1;
          type_due = 1'b0;
        end else begin
          type_due = 1'b1;
        end
      end
    end
    last_two = {last_two[7:0], b};
    if (fin) begin
      len = pos + OFS_W'(1);
      if (!found_code)
        units_due.push_back(make_rec(1'b0, '0, '0, '0, 8'h00, nubf_pkg::STATUS_NO_START,
                                     len, 1'b1));
      else if (at_limit)
        units_due.push_back(make_rec(1'b0, '0, '0, '0, 8'h00, nubf_pkg::STATUS_LIMIT,
                                     len - open_start, 1'b1));
      else
        units_due.push_back(make_rec(1'b1, units_given, open_start, len - open_start,
                                     type_due ? 8'h00 : open_type, nubf_pkg::STATUS_OK,
                                     '0, 1'b1));
      clear_scan();
    end else begin
      pos_ctr = pos + OFS_W'(1);
    end
  endtask

  always @(posedge clk) begin : watch
    unit_rec_t want;
    if (rst) begin
      clear_scan();
      max_units = CNT_W'(nubf_pkg::MAX_UNITS_RESET);
      units_due.delete();
    end else begin
      if (pop && !empty) begin
        if (units_due.size() == 0) begin
          log_error($sformatf("unit item %0d popped with none due", units_popped));
        end else begin
          want = units_due.pop_front();
          compare_field("unit_valid", 32'(unit_valid), 32'(want.valid));
          compare_field("unit_index", 32'(unit_index), 32'(want.index));
          compare_field("unit_offset", 32'(unit_offset), 32'(want.offset));
          compare_field("unit_size", 32'(unit_size), 32'(want.size));
          compare_field("unit_type", 32'(unit_type), 32'(want.utype));
          compare_field("status", 32'(status), 32'(want.status));
          compare_field("bytes_left", 32'(bytes_left), 32'(want.left));
          compare_field("done_res", 32'(done_res), 32'(want.done));
        end
        units_popped++;
      end
      if (push && !full) split_byte(data_byte, last);
      if (cfg_valid && cfg_ready) max_units = cfg_data;
    end
    owed = units_due.size();
  end

endmodule

@@ bench/nal_unit_boundary_finder_tb.sv @@
// ----------------------------------------------------------------------------
// nal_unit_boundary_finder_tb
// feeds annex b buffers into the boundary finder: a few hand-built buffers
// for the corner cases, then random buffers over several max_units values
// and idle/stall mixes; the monitor predicts and checks every unit item
// ----------------------------------------------------------------------------
module nal_unit_boundary_finder_tb;

  localparam int OFS_W         = nubf_pkg::OFFSET_BITS_DEF;
  localparam int CNT_W         = nubf_pkg::COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_BYTES   = 170;
  localparam int SETTLE_CYCLES = 4;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             push      = 1'b0;
  logic [7:0]       data_byte = 8'h00;
  logic             last      = 1'b0;
  logic             pop       = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;

  logic             full;
  logic             empty;
  logic             unit_valid;
  logic [CNT_W-1:0] unit_index;
  logic [OFS_W-1:0] unit_offset;
  logic [OFS_W-1:0] unit_size;
  logic [7:0]       unit_type;
  logic [1:0]       status;
  logic [OFS_W-1:0] bytes_left;
  logic             done_res;
  logic             cfg_ready;

  int fails;
  int owed;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int mid_cfg_pct = 0;
  int cycles      = 0;
  int phase_sent;

  logic [7:0] buf_bytes[$];

  int idle_tab[4]  = '{0, 49, 0, 10};
  int stall_tab[4] = '{0, 0, 49, 10};
  int limit_tab[8] = '{16383, 1, 2, 9000, 0, 3, -1, 16383};

  always #10 clk = ~clk;

  nal_unit_boundary_finder dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .last       (last),
    .empty      (empty),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_index (unit_index),
    .unit_offset(unit_offset),
    .unit_size  (unit_size),
    .unit_type  (unit_type),
    .status     (status),
    .bytes_left (bytes_left),
    .done_res   (done_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  nal_split_monitor u_watch (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .last       (last),
    .empty      (empty),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_index (unit_index),
    .unit_offset(unit_offset),
    .unit_size  (unit_size),
    .unit_type  (unit_type),
    .status     (status),
    .bytes_left (bytes_left),
    .done_res   (done_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (fails),
    .owed       (owed)
  );

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] payload_byte();
    int k;
    k = $urandom_range(99);
    // zeros and ones often, so near-miss start codes show up
    if (k < 20) return 8'h00;
    else if (k < 30) return nubf_pkg::START_CODE_END;
    else return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    last      <= fin;
    do @(posedge clk); while (full !== 1'b0);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_units(input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_buffer();
    int n;
    n = buf_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(buf_bytes[i], i == n - 1);
      // set the limit to a value from 0 to 4 in the middle of a buffer now and then
      if (i != n - 1 && $urandom_range(99) < mid_cfg_pct) begin
        wait_idle();
        write_max_units(CNT_W'($urandom_range(0, 4)));
      end
    end
    phase_sent += n;
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // leading byte, four-byte code, type ff, a zero type byte, last byte closes a unit
    buf_bytes = '{8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00};
    send_buffer();
    // 00 00 | 01 across two buffers is no code; second buffer ends on a fresh code
    buf_bytes = '{8'h00, 8'h00};
    send_buffer();
    buf_bytes = '{8'h01, 8'h00, 8'h00, 8'h01, 8'h33, 8'h00, 8'h00, 8'h01};
    send_buffer();
    // limit of zero still gives the first unit, then counts the rest
    wait_idle();
    write_max_units('0);
    buf_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h9C};
    send_buffer();

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      if (limit_tab[p] < 0) write_max_units(CNT_W'($urandom_range(1, 8)));
      else write_max_units(CNT_W'(limit_tab[p]));
      idle_pct    = idle_tab[p % 4];
      stall_pct   = stall_tab[p % 4];
      mid_cfg_pct = (p == 5) ? 3 : 0;
      phase_sent  = 0;
      while (phase_sent < PHASE_BYTES) begin
        buf_bytes.delete();
        if ($urandom_range(99) < 75) begin
          // well-formed: optional junk, then units with random payload
          n = $urandom_range(0, 3);
          repeat (n) buf_bytes.push_back(payload_byte());
          n = $urandom_range(1, 6);
          repeat (n) begin
            if ($urandom_range(3) == 0) buf_bytes.push_back(8'h00);
            buf_bytes.push_back(8'h00);
            buf_bytes.push_back(8'h00);
            buf_bytes.push_back(nubf_pkg::START_CODE_END);
            repeat ($urandom_range(0, 7)) buf_bytes.push_back(payload_byte());
          end
          // sometimes the buffer stops inside a start code or right at its end
          case ($urandom_range(9))
            0: begin
              buf_bytes.push_back(8'h00);
              buf_bytes.push_back(8'h00);
            end
            1: begin
              buf_bytes.push_back(8'h00);
              buf_bytes.push_back(8'h00);
              buf_bytes.push_back(nubf_pkg::START_CODE_END);
            end
            default: ;
          endcase
        end else begin
          repeat ($urandom_range(1, 12)) buf_bytes.push_back(payload_byte());
        end
        send_buffer();
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nubf_pkg.sv
rtl/core/nubf_front.sv
rtl/core/nubf_queue.sv
rtl/core/nubf_back.sv
rtl/core/nal_unit_boundary_finder.sv
bench/nal_split_monitor.sv
bench/nal_unit_boundary_finder_tb.sv
